@@ src/cbpt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbpt_pkg
// Shared types and constants of the clock bias PI trim block.
// ----------------------------------------------------------------------------
package cbpt_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 36;
    localparam int BIAS_W     = 32;
    localparam int BGAIN_W    = 32;
    localparam int BGAIN_FRAC = 24;
    localparam int MAXCH_W    = 36;
    localparam int GAIN_W     = 24;
    localparam int WORD_W     = 20;
    localparam int INTEG_W    = 48;
    localparam int MUL_W      = 32;
    localparam int PROD_W     = 2 * MUL_W;

    localparam logic [CFG_IDX_W-1:0] REG_BIAS_GAIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CHANGE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INT_GAIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_WORD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WORD_LIMIT   = 3'd5;

    localparam logic [BGAIN_W-1:0] BIAS_GAIN_RST  = 32'd16777216;
    localparam logic [MAXCH_W-1:0] MAX_CHANGE_RST = 36'hF_FFFF_FFFF;
    localparam logic [GAIN_W-1:0]  GAIN_RST       = 24'd65536;
    localparam logic [WORD_W-1:0]  WORD_LIMIT_RST = 20'hF_FFFF;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_E,
        ST_CLAMP,
        ST_MUL_PL,
        ST_MUL_PH,
        ST_MUL_IL,
        ST_MUL_IH,
        ST_DM,
        ST_INTEG,
        ST_SUM,
        ST_ROUND,
        ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        MOP_NONE,
        MOP_BIAS,
        MOP_P_LO,
        MOP_P_HI,
        MOP_I_LO,
        MOP_I_HI
    } t_mul_op;

    typedef struct packed {
        logic    busy;
        logic    take_in;
        t_mul_op mul_op;
        logic    ld_emag;
        logic    ld_acc;
        logic    ld_pm;
        logic    ld_dm;
        logic    ld_integ;
        logic    ld_sum;
        logic    ld_wmag;
        logic    ld_out;
    } t_ctrl;

endpackage

@@ src/cbpt_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbpt_mul
// Shared 32 x 32 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module cbpt_mul (
    input  logic                        i_clk,
    input  logic [cbpt_pkg::MUL_W-1:0]  i_a,
    input  logic [cbpt_pkg::MUL_W-1:0]  i_b,
    output logic [cbpt_pkg::PROD_W-1:0] o_p
);

    logic [cbpt_pkg::PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= cbpt_pkg::PROD_W'(i_a) * cbpt_pkg::PROD_W'(i_b);
    end

    assign o_p = r_p;

endmodule

@@ src/cbpt_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbpt_ctrl
// Sequencer that steps one item through the shared multiplier and adders.
// ----------------------------------------------------------------------------
module cbpt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_out_free,
    output cbpt_pkg::t_ctrl o_ctrl
);

    cbpt_pkg::t_state r_state;
    cbpt_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cbpt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cbpt_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = cbpt_pkg::ST_MUL_E;
                end
            end
            cbpt_pkg::ST_MUL_E:  n_state = cbpt_pkg::ST_CLAMP;
            cbpt_pkg::ST_CLAMP:  n_state = cbpt_pkg::ST_MUL_PL;
            cbpt_pkg::ST_MUL_PL: n_state = cbpt_pkg::ST_MUL_PH;
            cbpt_pkg::ST_MUL_PH: n_state = cbpt_pkg::ST_MUL_IL;
            cbpt_pkg::ST_MUL_IL: n_state = cbpt_pkg::ST_MUL_IH;
            cbpt_pkg::ST_MUL_IH: n_state = cbpt_pkg::ST_DM;
            cbpt_pkg::ST_DM:     n_state = cbpt_pkg::ST_INTEG;
            cbpt_pkg::ST_INTEG:  n_state = cbpt_pkg::ST_SUM;
            cbpt_pkg::ST_SUM:    n_state = cbpt_pkg::ST_ROUND;
            cbpt_pkg::ST_ROUND:  n_state = cbpt_pkg::ST_OUT;
            cbpt_pkg::ST_OUT: begin
                if (i_out_free) begin
                    n_state = cbpt_pkg::ST_IDLE;
                end
            end
            default: n_state = cbpt_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl        = '0;
        o_ctrl.mul_op = cbpt_pkg::MOP_NONE;
        o_ctrl.busy   = (r_state != cbpt_pkg::ST_IDLE);
        unique case (r_state)
            cbpt_pkg::ST_IDLE:   o_ctrl.take_in = i_valid;
            cbpt_pkg::ST_MUL_E:  o_ctrl.mul_op  = cbpt_pkg::MOP_BIAS;
            cbpt_pkg::ST_CLAMP:  o_ctrl.ld_emag = 1'b1;
            cbpt_pkg::ST_MUL_PL: o_ctrl.mul_op  = cbpt_pkg::MOP_P_LO;
            cbpt_pkg::ST_MUL_PH: begin
                o_ctrl.mul_op = cbpt_pkg::MOP_P_HI;
                o_ctrl.ld_acc = 1'b1;
            end
            cbpt_pkg::ST_MUL_IL: begin
                o_ctrl.mul_op = cbpt_pkg::MOP_I_LO;
                o_ctrl.ld_pm  = 1'b1;
            end
            cbpt_pkg::ST_MUL_IH: begin
                o_ctrl.mul_op = cbpt_pkg::MOP_I_HI;
                o_ctrl.ld_acc = 1'b1;
            end
            cbpt_pkg::ST_DM:     o_ctrl.ld_dm    = 1'b1;
            cbpt_pkg::ST_INTEG:  o_ctrl.ld_integ = 1'b1;
            cbpt_pkg::ST_SUM:    o_ctrl.ld_sum   = 1'b1;
            cbpt_pkg::ST_ROUND:  o_ctrl.ld_wmag  = 1'b1;
            cbpt_pkg::ST_OUT:    o_ctrl.ld_out   = i_out_free;
            default: o_ctrl.busy = 1'b1;
        endcase
    end

endmodule

@@ src/clock_bias_pi_trim.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_bias_pi_trim
// PI trim of an oscillator control word from measured clock bias, with
// error step clamp, saturating integral and output word saturation.
// ----------------------------------------------------------------------------
//   channel   direction   handshake            payload
//   input     in          i_valid / o_stall    i_bias
//   result    out         o_valid / i_stall    o_control_word, o_step_limited,
//                                              o_word_saturated
//   config    in          i_cfg_we             i_cfg_idx, i_cfg_data
//
// An item is accepted in idle; the next only after it has left the last step:
// five passes through the shared 32 x 32 multiplier, the error clamp after
// the first, then integral update, sum, rounding, output, one register stage each.
// o_stall is high in every step after acceptance and low in idle.
// A held result stalls the sequencer in its last step until it is taken.
// Synchronous active-low reset restores register defaults and clears the
// integral, the start flag and the result valid.
// ----------------------------------------------------------------------------
module clock_bias_pi_trim #(
    parameter int WORD_BITS = 20,
    parameter int FRAC_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [cbpt_pkg::BIAS_W-1:0]     i_bias,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [cbpt_pkg::WORD_W-1:0]     o_control_word,
    output logic                            o_step_limited,
    output logic                            o_word_saturated,
    input  logic                            i_cfg_we,
    input  logic [cbpt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cbpt_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SH_E  = cbpt_pkg::BGAIN_FRAC - FRAC_BITS;
    localparam int PM_W  = 61 - FRAC_BITS;
    localparam int S_W   = ((PM_W > cbpt_pkg::INTEG_W) ? PM_W : cbpt_pkg::INTEG_W) + 2;
    localparam int P_W   = cbpt_pkg::PROD_W;
    localparam int IW    = cbpt_pkg::INTEG_W;
    localparam int WW    = cbpt_pkg::WORD_W;
    localparam logic [P_W-1:0] HALF_E = P_W'((65'd1 << SH_E) >> 1);
    localparam logic [P_W-1:0] HALF_F = P_W'((65'd1 << FRAC_BITS) >> 1);
    localparam logic [S_W-1:0] IMAX   = {{(S_W - IW){1'b0}}, {IW{1'b1}}};
    localparam logic [31:0]    WMAX   = 32'((33'd1 << WORD_BITS) - 33'd1);

    cbpt_pkg::t_ctrl w_ctrl;

    logic [cbpt_pkg::BGAIN_W-1:0] r_bias_gain;
    logic [cbpt_pkg::MAXCH_W-1:0] r_max_change;
    logic [cbpt_pkg::GAIN_W-1:0]  r_prop_gain;
    logic [cbpt_pkg::GAIN_W-1:0]  r_int_gain;
    logic [WW-1:0]                r_initial_word;
    logic [WW-1:0]                r_word_limit;

    logic                         r_started;
    logic [IW-1:0]                r_integral;
    logic [cbpt_pkg::BIAS_W-1:0]  r_mag;
    logic                         r_err_neg;
    logic [cbpt_pkg::MAXCH_W-1:0] r_emag;
    logic                         r_step_lim;
    logic [P_W-1:0]               r_acc;
    logic [PM_W-1:0]              r_pm;
    logic [PM_W-1:0]              r_dm;
    logic [S_W-1:0]               r_sum;
    logic [S_W-1:0]               r_wmag;
    logic                         r_wneg;
    logic                         r_valid;
    logic [WW-1:0]                r_word;
    logic                         r_out_step;
    logic                         r_wsat;

    logic [cbpt_pkg::MUL_W-1:0]   w_mul_a;
    logic [cbpt_pkg::MUL_W-1:0]   w_mul_b;
    logic [P_W-1:0]               w_prod;
    logic [P_W-1:0]               n_eround;
    logic                         n_eover;
    logic [P_W-1:0]               n_gfull;
    logic [P_W-1:0]               n_ground;
    logic [S_W-1:0]               n_di;
    logic [S_W-1:0]               n_isum;
    logic [IW-1:0]                n_integral;
    logic [S_W-1:0]               n_p;
    logic [S_W-1:0]               n_rabs;
    logic [S_W-1:0]               n_rmag;
    logic [31:0]                  n_lim32;
    logic [WW-1:0]                n_lim;
    logic                         w_out_free;

    assign w_out_free = !r_valid || !i_stall;

    cbpt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_out_free (w_out_free),
        .o_ctrl     (w_ctrl)
    );

    always_comb begin
        case (w_ctrl.mul_op)
            cbpt_pkg::MOP_BIAS: begin
                w_mul_a = r_mag;
                w_mul_b = r_bias_gain;
            end
            cbpt_pkg::MOP_P_LO: begin
                w_mul_a = r_emag[31:0];
                w_mul_b = {8'd0, r_prop_gain};
            end
            cbpt_pkg::MOP_P_HI: begin
                w_mul_a = {28'd0, r_emag[35:32]};
                w_mul_b = {8'd0, r_prop_gain};
            end
            cbpt_pkg::MOP_I_LO: begin
                w_mul_a = r_emag[31:0];
                w_mul_b = {8'd0, r_int_gain};
            end
            cbpt_pkg::MOP_I_HI: begin
                w_mul_a = {28'd0, r_emag[35:32]};
                w_mul_b = {8'd0, r_int_gain};
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    cbpt_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    always_comb begin
        n_eround = (w_prod + HALF_E) >> SH_E;
        n_eover  = n_eround > {{(P_W - cbpt_pkg::MAXCH_W){1'b0}}, r_max_change};
        n_gfull  = r_acc + {w_prod[31:0], 32'd0};
        n_ground = n_gfull >> FRAC_BITS;

        n_di   = {{(S_W - PM_W){1'b0}}, r_dm};
        n_di   = r_err_neg ? (~n_di + 1'b1) : n_di;
        n_isum = {{(S_W - IW){1'b0}}, r_integral} + n_di;
        if (n_isum[S_W-1]) begin
            n_integral = '0;
        end else if (n_isum > IMAX) begin
            n_integral = '1;
        end else begin
            n_integral = n_isum[IW-1:0];
        end

        n_p = {{(S_W - PM_W){1'b0}}, r_pm};
        n_p = r_err_neg ? (~n_p + 1'b1) : n_p;

        n_rabs = r_sum[S_W-1] ? (S_W'(HALF_F) - r_sum) : (r_sum + S_W'(HALF_F));
        n_rmag = n_rabs >> FRAC_BITS;

        n_lim32 = ({12'd0, r_word_limit} < WMAX) ? {12'd0, r_word_limit} : WMAX;
        n_lim   = n_lim32[WW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias_gain    <= cbpt_pkg::BIAS_GAIN_RST;
            r_max_change   <= cbpt_pkg::MAX_CHANGE_RST;
            r_prop_gain    <= cbpt_pkg::GAIN_RST;
            r_int_gain     <= cbpt_pkg::GAIN_RST;
            r_initial_word <= '0;
            r_word_limit   <= cbpt_pkg::WORD_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cbpt_pkg::REG_BIAS_GAIN:    r_bias_gain    <= i_cfg_data[31:0];
                cbpt_pkg::REG_MAX_CHANGE:   r_max_change   <= i_cfg_data;
                cbpt_pkg::REG_PROP_GAIN:    r_prop_gain    <= i_cfg_data[23:0];
                cbpt_pkg::REG_INT_GAIN:     r_int_gain     <= i_cfg_data[23:0];
                cbpt_pkg::REG_INITIAL_WORD: r_initial_word <= i_cfg_data[WW-1:0];
                cbpt_pkg::REG_WORD_LIMIT:   r_word_limit   <= i_cfg_data[WW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started  <= 1'b0;
            r_integral <= '0;
            r_valid    <= 1'b0;
        end else begin
            if (w_ctrl.take_in) begin
                r_started <= 1'b1;
                if (!r_started) begin
                    r_integral <= {{(IW - WW){1'b0}}, r_initial_word} << FRAC_BITS;
                end
            end else if (w_ctrl.ld_integ) begin
                r_integral <= n_integral;
            end
            if (w_ctrl.ld_out) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.take_in) begin
            r_mag     <= i_bias[31] ? (~i_bias + 1'b1) : i_bias;
            r_err_neg <= !i_bias[31] && (i_bias != '0);
        end
        if (w_ctrl.ld_emag) begin
            r_emag     <= n_eover ? r_max_change : n_eround[cbpt_pkg::MAXCH_W-1:0];
            r_step_lim <= n_eover;
        end
        if (w_ctrl.ld_acc) begin
            r_acc <= w_prod + HALF_F;
        end
        if (w_ctrl.ld_pm) begin
            r_pm <= n_ground[PM_W-1:0];
        end
        if (w_ctrl.ld_dm) begin
            r_dm <= n_ground[PM_W-1:0];
        end
        if (w_ctrl.ld_sum) begin
            r_sum <= {{(S_W - IW){1'b0}}, r_integral} + n_p;
        end
        if (w_ctrl.ld_wmag) begin
            r_wmag <= n_rmag;
            r_wneg <= r_sum[S_W-1] && (n_rmag != '0);
        end
        if (w_ctrl.ld_out) begin
            r_out_step <= r_step_lim;
            if (r_wneg) begin
                r_word <= '0;
                r_wsat <= 1'b1;
            end else if (r_wmag > {{(S_W - WW){1'b0}}, n_lim}) begin
                r_word <= n_lim;
                r_wsat <= 1'b1;
            end else begin
                r_word <= r_wmag[WW-1:0];
                r_wsat <= 1'b0;
            end
        end
    end

    assign o_stall          = w_ctrl.busy;
    assign o_valid          = r_valid;
    assign o_control_word   = r_word;
    assign o_step_limited   = r_out_step;
    assign o_word_saturated = r_wsat;

`ifndef SYNTHESIS
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("block not busy after taking an item");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.ld_out |-> (!o_valid || !i_stall))
        else $error("result loaded over a held item");

    a_valid_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(w_ctrl.ld_out))
        else $error("result valid without a load");
`endif

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for clock_bias_pi_trim. A short table of bias items runs
// first, some with the control word typed in. Random items then run under a
// series of register settings, extremes included. Every result is checked
// field by field against the typed values or a fixed-point PI trim predictor kept in the bench.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int FRAC       = 16;
    localparam int N_PHASES   = 9;
    localparam int PHASE_LEN  = 210;
    localparam int TAIL_CYC   = 24;
    localparam int TIMEOUT_NS = 5_000_000;
    localparam int N_DIRECTED = 16;

    localparam logic [cbpt_pkg::CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [cbpt_pkg::CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    localparam longint INTEG_MAX = (longint'(1) <<< cbpt_pkg::INTEG_W) - longint'(1);

    typedef struct packed {
        logic [cbpt_pkg::WORD_W-1:0] word;
        logic                        step_lim;
        logic                        word_sat;
    } t_trim_res;

    typedef struct packed {
        logic [cbpt_pkg::BIAS_W-1:0] bias;
        logic                        typed;
        logic [cbpt_pkg::WORD_W-1:0] word;
        logic                        step_lim;
        logic                        word_sat;
    } t_bias_row;

    // initial_word is 0x80000 and every other register is at its reset value
    localparam t_bias_row DIRECTED_BIAS [N_DIRECTED] = '{
        '{32'h0000_0000, 1'b1, 20'h8_0000, 1'b0, 1'b0},
        '{32'h8000_0000, 1'b1, 20'hF_FFFF, 1'b1, 1'b1},
        '{32'h7FFF_FFFF, 1'b1, 20'h0_0000, 1'b1, 1'b1},
        '{32'h7FFF_FFFF, 1'b1, 20'h0_0000, 1'b1, 1'b1},
        '{32'h0000_0000, 1'b1, 20'h0_0000, 1'b0, 1'b0},
        '{32'hFFFF_FFFF, 1'b0, 20'h0_0000, 1'b0, 1'b0},
        '{32'h0000_0001, 1'b0, 20'h0_0000, 1'b0, 1'b0},
        '{32'hFFF0_0001, 1'b0, 20'h0_0000, 1'b0, 1'b0},
        '{32'hFFF0_0000, 1'b0, 20'h0_0000, 1'b0, 1'b0},
        '{32'h000F_FFFF, 1'b0, 20'h0_0000, 1'b0, 1'b0},
        '{32'h0010_0000, 1'b0, 20'h0_0000, 1'b0, 1'b0},
        '{32'h5555_5555, 1'b0, 20'h0_0000, 1'b0, 1'b0},
        '{32'hAAAA_AAAA, 1'b0, 20'h0_0000, 1'b0, 1'b0},
        '{32'h8000_0001, 1'b0, 20'h0_0000, 1'b0, 1'b0},
        '{32'hFFFF_8000, 1'b0, 20'h0_0000, 1'b0, 1'b0},
        '{32'h0000_0000, 1'b0, 20'h0_0000, 1'b0, 1'b0}
    };

    logic                            i_clk      = 1'b0;
    logic                            i_rst_n    = 1'b0;
    logic                            i_valid    = 1'b0;
    logic                            o_stall;
    logic [cbpt_pkg::BIAS_W-1:0]     i_bias     = '0;
    logic                            o_valid;
    logic                            i_stall    = 1'b0;
    logic [cbpt_pkg::WORD_W-1:0]     o_control_word;
    logic                            o_step_limited;
    logic                            o_word_saturated;
    logic                            i_cfg_we   = 1'b0;
    logic [cbpt_pkg::CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [cbpt_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    logic [cbpt_pkg::BGAIN_W-1:0] m_bias_gain  = cbpt_pkg::BIAS_GAIN_RST;
    logic [cbpt_pkg::MAXCH_W-1:0] m_max_change = cbpt_pkg::MAX_CHANGE_RST;
    logic [cbpt_pkg::GAIN_W-1:0]  m_prop_gain  = cbpt_pkg::GAIN_RST;
    logic [cbpt_pkg::GAIN_W-1:0]  m_int_gain   = cbpt_pkg::GAIN_RST;
    logic [cbpt_pkg::WORD_W-1:0]  m_init_word  = '0;
    logic [cbpt_pkg::WORD_W-1:0]  m_word_limit = cbpt_pkg::WORD_LIMIT_RST;
    longint                       m_integral   = 0;
    bit                           m_started    = 1'b0;

    t_trim_res   trim_expected[$];
    t_trim_res   want_res;
    int unsigned tx_idle_pct  = 0;
    int unsigned rx_stall_pct = 0;
    int          n_mismatch   = 0;

    clock_bias_pi_trim #(
        .WORD_BITS(cbpt_pkg::WORD_W),
        .FRAC_BITS(FRAC)
    ) u_dut (.*);

    always #5 i_clk = ~i_clk;

    function automatic logic [63:0] round_shr(logic [63:0] m, int sh);
        if (sh == 0) return m;
        return (m + (64'd1 << (sh - 1))) >> sh;
    endfunction

    function automatic t_trim_res predict_trim(logic [cbpt_pkg::BIAS_W-1:0] bias);
        logic [63:0] mag, emag, pm, dm;
        longint      p, di, sum, w, lim;
        logic        err_neg;
        t_trim_res   r;
        mag     = bias[cbpt_pkg::BIAS_W-1] ? (64'd1 << cbpt_pkg::BIAS_W) - 64'(bias)
                                           : 64'(bias);
        err_neg = !bias[cbpt_pkg::BIAS_W-1] && bias != '0;
        if (!m_started) begin
            m_integral = longint'(64'(m_init_word) << FRAC);
            m_started  = 1'b1;
        end
        emag       = round_shr(mag * 64'(m_bias_gain), cbpt_pkg::BGAIN_FRAC - FRAC);
        r.step_lim = emag > 64'(m_max_change);
        if (r.step_lim) emag = 64'(m_max_change);
        pm = round_shr(emag * 64'(m_prop_gain), FRAC);
        dm = round_shr(emag * 64'(m_int_gain), FRAC);
        p  = err_neg ? -longint'(pm) : longint'(pm);
        di = err_neg ? -longint'(dm) : longint'(dm);
        m_integral = m_integral + di;
        if (m_integral < 0) m_integral = 0;
        if (m_integral > INTEG_MAX) m_integral = INTEG_MAX;
        sum = p + m_integral;
        w   = sum < 0 ? -longint'(round_shr(64'(-sum), FRAC))
                      : longint'(round_shr(64'(sum), FRAC));
        // word port is exactly WORD_BITS wide, so word_limit is the bound
        lim        = longint'(m_word_limit);
        r.word_sat = (w < 0) || (w > lim);
        if (w < 0) w = 0;
        else if (w > lim) w = lim;
        r.word = w[cbpt_pkg::WORD_W-1:0];
        return r;
    endfunction

    task automatic write_reg(logic [cbpt_pkg::CFG_IDX_W-1:0] idx,
                             logic [cbpt_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            cbpt_pkg::REG_BIAS_GAIN:    m_bias_gain  = data[cbpt_pkg::BGAIN_W-1:0];
            cbpt_pkg::REG_MAX_CHANGE:   m_max_change = data[cbpt_pkg::MAXCH_W-1:0];
            cbpt_pkg::REG_PROP_GAIN:    m_prop_gain  = data[cbpt_pkg::GAIN_W-1:0];
            cbpt_pkg::REG_INT_GAIN:     m_int_gain   = data[cbpt_pkg::GAIN_W-1:0];
            cbpt_pkg::REG_INITIAL_WORD: m_init_word  = data[cbpt_pkg::WORD_W-1:0];
            cbpt_pkg::REG_WORD_LIMIT:   m_word_limit = data[cbpt_pkg::WORD_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send_bias(logic [cbpt_pkg::BIAS_W-1:0] bias, logic typed,
                             t_trim_res typed_res);
        t_trim_res pred;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_bias  <= bias;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pred = predict_trim(bias);
        trim_expected.push_back(typed ? typed_res : pred);
    endtask

    // drop valid, then hold until every result is in and the block is free
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (trim_expected.size() != 0 || o_stall) @(posedge i_clk);
    endtask

    always @(posedge i_clk) i_stall <= ($urandom_range(0, 99) < rx_stall_pct);

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (trim_expected.size() == 0) begin
                $error("unexpected item: control_word %0h", o_control_word);
                n_mismatch++;
            end else begin
                want_res = trim_expected.pop_front();
                if (o_control_word !== want_res.word) begin
                    $error("control_word: expected %0h, actual %0h",
                           want_res.word, o_control_word);
                    n_mismatch++;
                end
                if (o_step_limited !== want_res.step_lim) begin
                    $error("step_limited: expected %0b, actual %0b",
                           want_res.step_lim, o_step_limited);
                    n_mismatch++;
                end
                if (o_word_saturated !== want_res.word_sat) begin
                    $error("word_saturated: expected %0b, actual %0b",
                           want_res.word_sat, o_word_saturated);
                    n_mismatch++;
                end
            end
        end
    end

    initial begin
        logic [63:0]                     rnd;
        logic [63:0]                     mask;
        logic [cbpt_pkg::CFG_DATA_W-1:0] data;
        logic [cbpt_pkg::BIAS_W-1:0]     bias;
        int unsigned                     nbits;
        t_trim_res                       row_res;
        repeat (8) @(posedge i_clk);
        i_rst_n      <= 1'b1;
        tx_idle_pct  = 27;
        rx_stall_pct = 79;
        rnd = {$urandom, $urandom};
        write_reg(cbpt_pkg::REG_INITIAL_WORD, 36'h0_0008_0000);
        write_reg(REG_SPARE_6, rnd[cbpt_pkg::CFG_DATA_W-1:0]);
        i_cfg_we <= 1'b0;

        for (int k = 0; k < N_DIRECTED; k++) begin
            row_res = '{DIRECTED_BIAS[k].word, DIRECTED_BIAS[k].step_lim,
                        DIRECTED_BIAS[k].word_sat};
            send_bias(DIRECTED_BIAS[k].bias, DIRECTED_BIAS[k].typed, row_res);
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            wait_idle();
            case (ph / 3)
                0: begin
                    tx_idle_pct  = 27;
                    rx_stall_pct = 79;
                end
                1: begin
                    tx_idle_pct  = 79;
                    rx_stall_pct = 27;
                end
                default: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
            endcase
            // a random mix with the extremes, then all ones, then all zeros, then the random mix again
            for (int idx = 0; idx < 8; idx++) begin
                rnd = {$urandom, $urandom};
                if (ph == 1) data = '1;
                else if (ph == 2) data = '0;
                else if (rnd[63:61] == 3'd0) data = '0;
                else if (rnd[63:61] == 3'd1) data = '1;
                else data = rnd[cbpt_pkg::CFG_DATA_W-1:0]
                            >> $urandom_range(0, cbpt_pkg::CFG_DATA_W - 1);
                write_reg(idx[cbpt_pkg::CFG_IDX_W-1:0], data);
            end
            i_cfg_we <= 1'b0;

            for (int n = 0; n < PHASE_LEN; n++) begin
                rnd   = {$urandom, $urandom};
                nbits = $urandom_range(1, cbpt_pkg::BIAS_W);
                mask  = (64'd1 << nbits) - 64'd1;
                if (rnd[63:60] == 4'd0) begin
                    bias = rnd[cbpt_pkg::BIAS_W-1:0];
                end else begin
                    bias = rnd[cbpt_pkg::BIAS_W-1:0] & mask[cbpt_pkg::BIAS_W-1:0];
                    if (rnd[59]) bias = -bias;
                end
                send_bias(bias, 1'b0, '0);
            end
        end

        wait_idle();
        repeat (TAIL_CYC) @(posedge i_clk);
        if (n_mismatch == 0) $display("tb_top: PASS");
        else $display("tb_top: FAIL");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
